[rtl/bop_pkg.sv]
package bop_pkg;

   // operation codes of an input transfer
   localparam logic [2:0] OP_SAMPLE      = 3'd0;
   localparam logic [2:0] OP_BRANCH_ON   = 3'd1;
   localparam logic [2:0] OP_BRANCH_OFF  = 3'd2;
   localparam logic [2:0] OP_PROTECT_EN  = 3'd3;
   localparam logic [2:0] OP_PROTECT_DIS = 3'd4;

   // event codes of a result transfer
   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_OVER        = 3'd1;
   localparam logic [2:0] EV_OVER_CLEAR  = 3'd2;
   localparam logic [2:0] EV_TRIP        = 3'd3;
   localparam logic [2:0] EV_RECOVER     = 3'd4;

   // configuration register indexes
   localparam int unsigned NUM_THRESH     = 5;
   localparam logic [2:0]  CSR_TRIP_COUNT = 3'd5;
   localparam logic [2:0]  CSR_RECOVERY   = 3'd6;

   // register widths and reset values
   localparam int unsigned THRESH_W     = 15;
   localparam int unsigned COUNT_W      = 8;
   localparam int unsigned RECOVERY_W   = 16;
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned ALU_W        = 34;
   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 15'h7fff;
   localparam logic [COUNT_W-1:0]    TRIP_RESET     = 8'd1;
   localparam logic [RECOVERY_W-1:0] RECOVERY_RESET = 16'd5000;
   localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'd255;

   // status bit positions
   localparam int unsigned ST_ONLINE  = 0;
   localparam int unsigned ST_ENABLED = 1;
   localparam int unsigned ST_TRIPPED = 2;
   localparam int unsigned ST_MANUAL  = 3;
   localparam int unsigned ST_POWERED = 4;
   localparam int unsigned ST_OVER    = 5;

   // operand selection of the shared subtract/compare unit
   typedef enum logic [1:0] {
      SEL_SAMPLE,
      SEL_COUNT,
      SEL_ELAPSED,
      SEL_RECOVERY
   } alu_sel_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_APPLY,
      S_SAMPLE_CMP,
      S_COUNT_CMP,
      S_TIME_SUB,
      S_TIME_CMP,
      S_OVER_COMMIT,
      S_OVER_EMIT,
      S_TRIP_COMMIT,
      S_TRIP_EMIT,
      S_REC_COMMIT,
      S_REC_EMIT,
      S_DONE_EMIT
   } state_type;

endpackage

[rtl/branch_overcurrent_protector_unit.sv]
// channel   direction  handshake                   payload
// req_      in         req_valid / req_ready       operation, branch, shunt_sample, now_ms
// rsp_      out        rsp_valid / rsp_ready       out_branch .. last, one to three per item
// csr_      in         csr_we                      csr_index, csr_wdata
//
// from its transfer until req_ready rises again, a sample item takes four passes
// through the shared subtract/compare unit, three commit steps, then one result
// step for each event, or a single result step when there is none; every other item
// takes one apply step and one result step
// a result step waits while the output register holds a result not yet taken
// reset is synchronous and active high; it clears all control state and needs no sweep
module branch_overcurrent_protector_unit #(
   parameter int unsigned NUM_BRANCHES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [2:0]  req_branch,
   input  logic [15:0] req_shunt_sample,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_branch,
   output logic [5:0]  rsp_status_bits,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_gate_drive,
   output logic [31:0] rsp_trip_total,
   output logic        rsp_protect_on,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bop_pkg::*;

   localparam int unsigned BR_W = $clog2(NUM_BRANCHES);
   localparam logic [2:0]  NB   = 3'(NUM_BRANCHES);

   // configuration registers
   logic [THRESH_W-1:0]   thresh_ff [NUM_THRESH];
   logic [COUNT_W-1:0]    trip_samples_ff;
   logic [RECOVERY_W-1:0] recovery_ff;

   // branch state
   logic                    protect_ff, protect_in;
   logic [NUM_BRANCHES-1:0] online_ff, online_in;
   logic [NUM_BRANCHES-1:0] enabled_ff, enabled_in;
   logic [NUM_BRANCHES-1:0] manual_ff, manual_in;
   logic [NUM_BRANCHES-1:0] tripped_ff, tripped_in;
   logic [NUM_BRANCHES-1:0] over_ff, over_in;
   logic [COUNT_W-1:0]      count_ff [NUM_BRANCHES];
   logic [COUNT_W-1:0]      count_in [NUM_BRANCHES];
   logic [TIME_W-1:0]       stamp_ff [NUM_BRANCHES];
   logic [TIME_W-1:0]       counter_ff [NUM_BRANCHES];
   logic [TIME_W-1:0]       counter_in [NUM_BRANCHES];
   logic                    stamp_we;

   // sequencer and item registers
   state_type       state_ff, state_in;
   logic [2:0]      op_ff, op_in;
   logic [2:0]      branch_ff, branch_in;
   logic [15:0]     sample_ff, sample_in;
   logic [31:0]     now_ff, now_in;
   logic            hit_ff, hit_in;
   logic [7:0]      cnt_ff, cnt_in;
   logic            chg_ff, chg_in;
   logic            trip_fire_ff, trip_fire_in;
   logic            rec_fire_ff, rec_fire_in;
   logic [31:0]     elapsed_ff, elapsed_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_branch_ff, rsp_branch_in;
   logic [5:0]      rsp_status_ff, rsp_status_in;
   logic [2:0]      rsp_event_ff, rsp_event_in;
   logic            rsp_gate_ff, rsp_gate_in;
   logic [31:0]     rsp_total_ff, rsp_total_in;
   logic            rsp_protect_ff, rsp_protect_in;
   logic            rsp_last_ff, rsp_last_in;

   // current branch view
   logic [BR_W-1:0] idx;
   logic            br_valid;
   logic            req_br_valid;
   logic            cur_powered;
   logic [5:0]      cur_status;
   logic            slot_free;
   logic            emit;
   logic [2:0]      emit_event;
   logic            emit_last;

   // shared unit
   alu_sel_type     alu_sel;
   logic [31:0]     alu_diff;
   logic            alu_ge;
   logic [31:0]     stamp_sel;

   assign idx          = branch_ff[BR_W-1:0];
   assign br_valid     = branch_ff < NB;
   assign req_br_valid = req_branch < NB;
   assign cur_powered  = enabled_ff[idx] & enabled_ff[0];
   assign slot_free    = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      cur_status             = '0;
      cur_status[ST_ONLINE]  = online_ff[idx];
      cur_status[ST_ENABLED] = enabled_ff[idx];
      cur_status[ST_TRIPPED] = tripped_ff[idx];
      cur_status[ST_MANUAL]  = manual_ff[idx];
      cur_status[ST_POWERED] = cur_powered;
      cur_status[ST_OVER]    = over_ff[idx];
   end

   // operand choice per step; a trip in this item restarts the hold time now
   assign stamp_sel = trip_fire_ff ? now_ff : stamp_ff[idx];

   always_comb begin
      unique case (state_ff)
         S_COUNT_CMP: alu_sel = SEL_COUNT;
         S_TIME_SUB:  alu_sel = SEL_ELAPSED;
         S_TIME_CMP:  alu_sel = SEL_RECOVERY;
         default:     alu_sel = SEL_SAMPLE;
      endcase
   end

   bop_cmp_unit u_cmp (
      .sel          (alu_sel),
      .thresh       (thresh_ff[idx]),
      .sample       (sample_ff),
      .count        (cnt_ff),
      .trip_samples (trip_samples_ff),
      .now_ms       (now_ff),
      .stamp        (stamp_sel),
      .elapsed      (elapsed_ff),
      .recovery     (recovery_ff),
      .diff_lo      (alu_diff),
      .ge           (alu_ge)
   );

   // sequencer: next state and branch state updates
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      branch_in    = branch_ff;
      sample_in    = sample_ff;
      now_in       = now_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      chg_in       = chg_ff;
      trip_fire_in = trip_fire_ff;
      rec_fire_in  = rec_fire_ff;
      elapsed_in   = elapsed_ff;
      protect_in   = protect_ff;
      online_in    = online_ff;
      enabled_in   = enabled_ff;
      manual_in    = manual_ff;
      tripped_in   = tripped_ff;
      over_in      = over_ff;
      count_in     = count_ff;
      counter_in   = counter_ff;
      stamp_we     = 1'b0;
      emit         = 1'b0;
      emit_event   = EV_NONE;
      emit_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               branch_in = req_branch;
               sample_in = req_shunt_sample;
               now_in    = req_now_ms;
               if (req_operation == OP_SAMPLE && req_br_valid) begin
                  state_in = S_SAMPLE_CMP;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end

         S_APPLY: begin
            unique case (op_ff)
               OP_BRANCH_ON, OP_BRANCH_OFF: begin
                  if (br_valid) begin
                     enabled_in[idx] = (op_ff == OP_BRANCH_ON);
                     manual_in[idx]  = (op_ff == OP_BRANCH_OFF);
                     tripped_in[idx] = 1'b0;
                  end
               end
               OP_PROTECT_EN: begin
                  protect_in = 1'b1;
                  for (int i = 0; i < NUM_BRANCHES; i++) count_in[i] = '0;
               end
               OP_PROTECT_DIS: begin
                  protect_in = 1'b0;
                  for (int i = 0; i < NUM_BRANCHES; i++) begin
                     count_in[i] = '0;
                     if (tripped_ff[i] && !manual_ff[i]) begin
                        tripped_in[i] = 1'b0;
                        enabled_in[i] = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
            state_in = S_DONE_EMIT;
         end

         // reading above threshold while powered and not switched off
         S_SAMPLE_CMP: begin
            hit_in = cur_powered & ~manual_ff[idx] & ~alu_ge;
            if (cur_powered && !manual_ff[idx] && !alu_ge) begin
               cnt_in = (count_ff[idx] == COUNT_MAX) ? COUNT_MAX : count_ff[idx] + 8'd1;
            end else begin
               cnt_in = '0;
            end
            state_in = S_COUNT_CMP;
         end

         S_COUNT_CMP: begin
            trip_fire_in = protect_ff & hit_ff & alu_ge & ~tripped_ff[idx];
            state_in     = S_TIME_SUB;
         end

         S_TIME_SUB: begin
            elapsed_in = alu_diff;
            state_in   = S_TIME_CMP;
         end

         S_TIME_CMP: begin
            rec_fire_in = protect_ff & ~manual_ff[idx] & (tripped_ff[idx] | trip_fire_ff)
                          & alu_ge;
            state_in    = S_OVER_COMMIT;
         end

         S_OVER_COMMIT: begin
            online_in[idx] = 1'b1;
            over_in[idx]   = hit_ff;
            count_in[idx]  = cnt_ff;
            chg_in         = hit_ff ^ over_ff[idx];
            state_in       = (hit_ff ^ over_ff[idx]) ? S_OVER_EMIT : S_TRIP_COMMIT;
         end

         S_OVER_EMIT: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_event = hit_ff ? EV_OVER : EV_OVER_CLEAR;
               emit_last  = ~(trip_fire_ff | rec_fire_ff);
               state_in   = S_TRIP_COMMIT;
            end
         end

         S_TRIP_COMMIT: begin
            if (trip_fire_ff) begin
               tripped_in[idx] = 1'b1;
               enabled_in[idx] = 1'b0;
               stamp_we        = 1'b1;
               counter_in[idx] = counter_ff[idx] + 32'd1;
               state_in        = S_TRIP_EMIT;
            end else begin
               state_in = S_REC_COMMIT;
            end
         end

         S_TRIP_EMIT: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_event = EV_TRIP;
               emit_last  = ~rec_fire_ff;
               state_in   = S_REC_COMMIT;
            end
         end

         S_REC_COMMIT: begin
            if (rec_fire_ff) begin
               enabled_in[idx] = 1'b1;
               tripped_in[idx] = 1'b0;
               count_in[idx]   = '0;
               state_in        = S_REC_EMIT;
            end else if (!chg_ff && !trip_fire_ff) begin
               state_in = S_DONE_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_REC_EMIT: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_event = EV_RECOVER;
               state_in   = S_IDLE;
            end
         end

         S_DONE_EMIT: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // output register loads from the branch state as it stands after each step
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_branch_in  = rsp_branch_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_gate_in    = rsp_gate_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_protect_in = rsp_protect_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_branch_in  = branch_ff;
         rsp_status_in  = br_valid ? cur_status : '0;
         rsp_event_in   = emit_event;
         rsp_gate_in    = br_valid & enabled_ff[idx];
         rsp_total_in   = br_valid ? counter_ff[idx] : '0;
         rsp_protect_in = protect_ff;
         rsp_last_in    = emit_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         protect_ff      <= 1'b0;
         online_ff       <= '0;
         enabled_ff      <= '0;
         manual_ff       <= '1;
         tripped_ff      <= '0;
         over_ff         <= '0;
         trip_samples_ff <= TRIP_RESET;
         recovery_ff     <= RECOVERY_RESET;
         for (int i = 0; i < NUM_THRESH; i++) thresh_ff[i] <= THRESH_RESET;
         for (int i = 0; i < NUM_BRANCHES; i++) begin
            count_ff[i]   <= '0;
            counter_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         protect_ff   <= protect_in;
         online_ff    <= online_in;
         enabled_ff   <= enabled_in;
         manual_ff    <= manual_in;
         tripped_ff   <= tripped_in;
         over_ff      <= over_in;
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         // configuration writes
         if (csr_we) begin
            if (csr_index < 3'(NUM_THRESH)) begin
               thresh_ff[csr_index] <= csr_wdata[THRESH_W-1:0];
            end else if (csr_index == CSR_TRIP_COUNT) begin
               trip_samples_ff <= csr_wdata[COUNT_W-1:0];
            end else if (csr_index == CSR_RECOVERY) begin
               recovery_ff <= csr_wdata[RECOVERY_W-1:0];
            end
         end
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      branch_ff      <= branch_in;
      sample_ff      <= sample_in;
      now_ff         <= now_in;
      hit_ff         <= hit_in;
      cnt_ff         <= cnt_in;
      chg_ff         <= chg_in;
      trip_fire_ff   <= trip_fire_in;
      rec_fire_ff    <= rec_fire_in;
      elapsed_ff     <= elapsed_in;
      rsp_branch_ff  <= rsp_branch_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_gate_ff    <= rsp_gate_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_protect_ff <= rsp_protect_in;
      rsp_last_ff    <= rsp_last_in;
      if (stamp_we) begin
         stamp_ff[idx] <= now_ff;
      end
   end

   assign req_ready       = (state_ff == S_IDLE) & ~reset;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_branch  = rsp_branch_ff;
   assign rsp_status_bits = rsp_status_ff;
   assign rsp_event_code  = rsp_event_ff;
   assign rsp_gate_drive  = rsp_gate_ff;
   assign rsp_trip_total  = rsp_total_ff;
   assign rsp_protect_on  = rsp_protect_ff;
   assign rsp_last        = rsp_last_ff;

   // a tripped branch is never driven on
   a_trip_off: assert property (@(posedge clock) disable iff (reset)
      (tripped_ff & enabled_ff) == '0)
      else $error("tripped branch still enabled");

   // a tripped branch is never one switched off by hand
   a_trip_manual: assert property (@(posedge clock) disable iff (reset)
      (tripped_ff & manual_ff) == '0)
      else $error("tripped branch marked manual off");

   // a result is only loaded once the previous one has left
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result overwrote a pending transfer");

   // the sequencer leaves idle right after an input transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // a branch out of limit state holds a zero count
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      !over_ff[idx] && br_valid |-> count_ff[idx] == '0)
      else $error("nonzero count without over limit");

endmodule

[rtl/bop_cmp_unit.sv]
module bop_cmp_unit (
   input  bop_pkg::alu_sel_type sel,
   input  logic [14:0]          thresh,
   input  logic [15:0]          sample,
   input  logic [7:0]           count,
   input  logic [7:0]           trip_samples,
   input  logic [31:0]          now_ms,
   input  logic [31:0]          stamp,
   input  logic [31:0]          elapsed,
   input  logic [15:0]          recovery,
   output logic [31:0]          diff_lo,
   output logic                 ge
);
   import bop_pkg::*;

   logic [ALU_W-1:0] op_a;
   logic [ALU_W-1:0] op_b;
   logic [ALU_W-1:0] diff;

   // operand selection, all values widened to a common signed width
   always_comb begin
      unique case (sel)
         SEL_SAMPLE: begin
            op_a = {{(ALU_W-THRESH_W){1'b0}}, thresh};
            op_b = {{(ALU_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
         end
         SEL_COUNT: begin
            op_a = {{(ALU_W-COUNT_W){1'b0}}, count};
            op_b = {{(ALU_W-COUNT_W){1'b0}}, trip_samples};
         end
         SEL_ELAPSED: begin
            op_a = {{(ALU_W-TIME_W){1'b0}}, now_ms};
            op_b = {{(ALU_W-TIME_W){1'b0}}, stamp};
         end
         SEL_RECOVERY: begin
            op_a = {{(ALU_W-TIME_W){1'b0}}, elapsed};
            op_b = {{(ALU_W-RECOVERY_W){1'b0}}, recovery};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // one subtractor serves every compare and the wrapping time difference
   assign diff    = op_a - op_b;
   assign ge      = ~diff[ALU_W-1];
   assign diff_lo = diff[TIME_W-1:0];

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import bop_pkg::*;

   localparam int unsigned BRANCHES      = 5;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned PHASE_ITEMS   = 69;

   typedef struct packed {
      logic [2:0]  branch;
      logic [5:0]  status;
      logic [2:0]  event_code;
      logic        gate_drive;
      logic [31:0] trip_total;
      logic        protect_on;
      logic        last;
   } branch_report_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [2:0]  req_branch;
   logic [15:0] req_shunt_sample;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_out_branch;
   logic [5:0]  rsp_status_bits;
   logic [2:0]  rsp_event_code;
   logic        rsp_gate_drive;
   logic [31:0] rsp_trip_total;
   logic        rsp_protect_on;
   logic        rsp_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   branch_overcurrent_protector_unit #(
      .NUM_BRANCHES(BRANCHES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_branch       (req_branch),
      .req_shunt_sample (req_shunt_sample),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_branch   (rsp_out_branch),
      .rsp_status_bits  (rsp_status_bits),
      .rsp_event_code   (rsp_event_code),
      .rsp_gate_drive   (rsp_gate_drive),
      .rsp_trip_total   (rsp_trip_total),
      .rsp_protect_on   (rsp_protect_on),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // shadow of the fuse configuration and per-branch state
   logic [THRESH_W-1:0]   limit_raw [BRANCHES];
   logic [COUNT_W-1:0]    trip_need;
   logic [RECOVERY_W-1:0] hold_ms;
   logic                  protect_q;
   logic [BRANCHES-1:0]   enabled_q;
   logic [BRANCHES-1:0]   manual_q;
   logic [BRANCHES-1:0]   tripped_q;
   logic [BRANCHES-1:0]   over_q;
   logic [BRANCHES-1:0]   online_q;
   logic [COUNT_W-1:0]    over_run   [BRANCHES];
   logic [TIME_W-1:0]     trip_time  [BRANCHES];
   logic [31:0]           trip_count [BRANCHES];

   branch_report_type expected_reports [$];
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       mismatches;
   int unsigned       idle_cycles;
   logic [31:0]       ms_now;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic is_powered(logic [2:0] b);
      return (b == 0) ? enabled_q[0] : (enabled_q[b] & enabled_q[0]);
   endfunction

   function automatic branch_report_type snapshot(logic [2:0] b, logic [2:0] ev);
      branch_report_type r;
      r            = '0;
      r.branch     = b;
      r.event_code = ev;
      r.protect_on = protect_q;
      if (b < BRANCHES) begin
         r.status[ST_ONLINE]  = online_q[b];
         r.status[ST_ENABLED] = enabled_q[b];
         r.status[ST_TRIPPED] = tripped_q[b];
         r.status[ST_MANUAL]  = manual_q[b];
         r.status[ST_POWERED] = is_powered(b);
         r.status[ST_OVER]    = over_q[b];
         r.gate_drive         = enabled_q[b];
         r.trip_total         = trip_count[b];
      end
      return r;
   endfunction

   task automatic clear_shadow();
      for (int i = 0; i < BRANCHES; i++) begin
         limit_raw[i]  = THRESH_RESET;
         over_run[i]   = '0;
         trip_time[i]  = '0;
         trip_count[i] = '0;
      end
      trip_need = TRIP_RESET;
      hold_ms   = RECOVERY_RESET;
      protect_q = 1'b0;
      enabled_q = '0;
      manual_q  = '1;
      tripped_q = '0;
      over_q    = '0;
      online_q  = '0;
   endtask

   // fuse behavior for one accepted item, appends the reports it causes
   task automatic predict_reports(input logic [2:0] op, input logic [2:0] b,
                                  input logic [15:0] raw, input logic [31:0] now);
      branch_report_type found [$];
      logic              was_over;
      logic              in_range;
      logic [31:0]       elapsed;
      in_range = (b < BRANCHES);
      if (op == OP_SAMPLE && in_range) begin
         was_over    = over_q[b];
         online_q[b] = 1'b1;
         if (is_powered(b) && !manual_q[b] &&
             $signed(raw) > $signed({1'b0, limit_raw[b]})) begin
            if (over_run[b] < COUNT_MAX) over_run[b]++;
            over_q[b] = 1'b1;
         end else begin
            over_run[b] = '0;
            over_q[b]   = 1'b0;
         end
         if (over_q[b] != was_over)
            found.push_back(snapshot(b, over_q[b] ? EV_OVER : EV_OVER_CLEAR));
         if (protect_q) begin
            if (over_q[b] && over_run[b] >= trip_need && !tripped_q[b]) begin
               tripped_q[b]  = 1'b1;
               enabled_q[b]  = 1'b0;
               trip_time[b]  = now;
               trip_count[b] = trip_count[b] + 32'd1;
               found.push_back(snapshot(b, EV_TRIP));
            end
            elapsed = now - trip_time[b];
            if (!manual_q[b] && tripped_q[b] && elapsed >= {16'd0, hold_ms}) begin
               enabled_q[b] = 1'b1;
               tripped_q[b] = 1'b0;
               over_run[b]  = '0;
               found.push_back(snapshot(b, EV_RECOVER));
            end
         end
      end else if ((op == OP_BRANCH_ON || op == OP_BRANCH_OFF) && in_range) begin
         enabled_q[b] = (op == OP_BRANCH_ON);
         manual_q[b]  = (op != OP_BRANCH_ON);
         tripped_q[b] = 1'b0;
      end else if (op == OP_PROTECT_EN) begin
         protect_q = 1'b1;
         for (int i = 0; i < BRANCHES; i++) over_run[i] = '0;
      end else if (op == OP_PROTECT_DIS) begin
         protect_q = 1'b0;
         for (int i = 0; i < BRANCHES; i++) begin
            over_run[i] = '0;
            if (tripped_q[i] && !manual_q[i]) begin
               tripped_q[i] = 1'b0;
               enabled_q[i] = 1'b1;
            end
         end
      end
      if (found.size() == 0) found.push_back(snapshot(b, EV_NONE));
      found[found.size()-1].last = 1'b1;
      foreach (found[k]) expected_reports.push_back(found[k]);
   endtask

   // one request transfer; called and returns at a falling edge
   task automatic send_item(input logic [2:0] op, input logic [2:0] b,
                            input logic [15:0] raw, input logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_branch       <= b;
      req_shunt_sample <= raw;
      req_now_ms       <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reports(op, b, raw, now);
      @(negedge clock);
   endtask

   // drop valid and wait until every report is in and the block is ready
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0 || !req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx < NUM_THRESH) limit_raw[idx] = data[THRESH_W-1:0];
      else if (idx == CSR_TRIP_COUNT) trip_need = data[COUNT_W-1:0];
      else if (idx == CSR_RECOVERY) hold_ms = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // default state: nothing powered, out-of-range branches, unused codes
   task automatic test_reset_state();
      send_item(OP_SAMPLE, 3'd0, 16'h7fff, 32'd0);
      send_item(3'd5, 3'd1, 16'h1234, 32'd1);
      send_item(3'd7, 3'd7, 16'hffff, 32'hffff_ffff);
      send_item(OP_BRANCH_ON, 3'd6, 16'h0000, 32'd2);
      send_item(OP_PROTECT_DIS, 3'd5, 16'h8000, 32'd3);
   endtask

   // zero trip count and zero hold, then longest hold
   task automatic test_trip_recover();
      wait_idle();
      write_csr(3'd0, 16'd100);
      write_csr(3'd1, 16'd0);
      write_csr(CSR_TRIP_COUNT, 16'h0000);
      write_csr(CSR_RECOVERY, 16'h0000);
      send_item(OP_PROTECT_EN, 3'd0, 16'h0000, 32'd0);
      send_item(OP_BRANCH_ON, 3'd0, 16'h0000, 32'd0);
      send_item(OP_BRANCH_ON, 3'd1, 16'h0000, 32'd0);
      // over limit, trip and recover in one sample
      send_item(OP_SAMPLE, 3'd1, 16'd1, 32'd10);
      send_item(OP_SAMPLE, 3'd1, 16'h8000, 32'd11);
      // main branch trips and recovers at once
      send_item(OP_SAMPLE, 3'd0, 16'h7fff, 32'd20);
      wait_idle();
      write_csr(CSR_TRIP_COUNT, 16'ha503);
      write_csr(CSR_RECOVERY, 16'hffff);
      repeat (3) send_item(OP_SAMPLE, 3'd1, 16'h7fff, 32'd100);
      // one ms short of the hold, then exactly the hold
      send_item(OP_SAMPLE, 3'd1, 16'h7fff, 32'd100 + 32'd65534);
      send_item(OP_SAMPLE, 3'd1, 16'h7fff, 32'd100 + 32'd65535);
      send_item(OP_BRANCH_OFF, 3'd1, 16'h0000, 32'd0);
      send_item(OP_SAMPLE, 3'd1, 16'h7fff, 32'd200000);
   endtask

   // hold time across the 32 bit wrap, then release by disable
   task automatic test_time_wrap();
      wait_idle();
      write_csr(3'd2, 16'd5);
      write_csr(CSR_TRIP_COUNT, 16'h0001);
      write_csr(CSR_RECOVERY, 16'd10);
      send_item(OP_BRANCH_ON, 3'd2, 16'h0000, 32'd0);
      send_item(OP_SAMPLE, 3'd2, 16'd6, 32'hffff_fffa);
      send_item(OP_SAMPLE, 3'd2, 16'd0, 32'd3);
      send_item(OP_SAMPLE, 3'd2, 16'd0, 32'd4);
      send_item(OP_SAMPLE, 3'd2, 16'h7fff, 32'd100);
      send_item(OP_PROTECT_DIS, 3'd2, 16'h0000, 32'd101);
   endtask

   task automatic configure_phase(input int unsigned phase);
      logic [15:0] data;
      for (int i = 0; i < NUM_THRESH; i++) begin
         case (phase)
            0: data = {1'($urandom), 15'($urandom_range(400))};
            1: data = (i == 4) ? 16'($urandom) : ((i % 2) ? 16'h7fff : 16'h8000);
            default: data = 16'($urandom);
         endcase
         write_csr(3'(i), data);
      end
      case (phase)
         0: begin
            write_csr(CSR_TRIP_COUNT, {8'($urandom), 8'($urandom_range(4, 1))});
            write_csr(CSR_RECOVERY, 16'($urandom_range(300)));
         end
         1: begin
            write_csr(CSR_TRIP_COUNT, {8'($urandom), 8'hff});
            write_csr(CSR_RECOVERY, 16'hffff);
         end
         default: begin
            write_csr(CSR_TRIP_COUNT, {8'($urandom), 8'($urandom_range(2))});
            write_csr(CSR_RECOVERY, 16'($urandom_range(50)));
         end
      endcase
   endtask

   // mostly samples around the threshold with advancing time
   task automatic send_random_items(input int unsigned count);
      logic [2:0]  op;
      logic [2:0]  b;
      logic [15:0] raw;
      int unsigned pick;
      int          thr;
      int          level;
      repeat (count) begin
         pick = $urandom_range(99);
         b    = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         raw  = 16'($urandom);
         if (pick < 72) op = OP_SAMPLE;
         else if (pick < 82) op = OP_BRANCH_ON;
         else if (pick < 87) op = OP_BRANCH_OFF;
         else if (pick < 93) op = OP_PROTECT_EN;
         else if (pick < 96) op = OP_PROTECT_DIS;
         else op = 3'($urandom_range(7, 5));
         if (op == OP_SAMPLE) begin
            thr = (b < BRANCHES) ? int'(limit_raw[b]) : 0;
            case ($urandom_range(3))
               0, 1: begin
                  level = thr + int'($urandom_range(5)) - 2;
                  if (level > 32767) level = 32767;
                  raw = 16'(level);
               end
               2: raw = 16'($urandom);
               default: begin
                  case ($urandom_range(3))
                     0: raw = 16'h8000;
                     1: raw = 16'h7fff;
                     2: raw = 16'h0000;
                     default: raw = 16'hffff;
                  endcase
               end
            endcase
         end
         // time mostly creeps forward, sometimes jumps anywhere
         if ($urandom_range(19) == 0) ms_now = $urandom;
         else ms_now = ms_now + $urandom_range(hold_ms / 4 + 3);
         send_item(op, b, raw, ms_now);
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         configure_phase(phase);
         send_random_items(PHASE_ITEMS);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   // compare each report transfer with the oldest expectation
   always @(posedge clock) begin
      branch_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none actual branch %0d event %0d",
                     $time, rsp_out_branch, rsp_event_code);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("out_branch", 32'(want.branch), 32'(rsp_out_branch));
            check_field("status_bits", 32'(want.status), 32'(rsp_status_bits));
            check_field("event_code", 32'(want.event_code), 32'(rsp_event_code));
            check_field("gate_drive", 32'(want.gate_drive), 32'(rsp_gate_drive));
            check_field("trip_total", want.trip_total, rsp_trip_total);
            check_field("protect_on", 32'(want.protect_on), 32'(rsp_protect_on));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_SAMPLE;
      req_branch       = '0;
      req_shunt_sample = '0;
      req_now_ms       = '0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      send_idle_pct    = 32;
      recv_idle_pct    = 73;
      mismatches       = 0;
      ms_now           = '0;
      clear_shadow();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_trip_recover();
      test_time_wrap();
      test_random_traffic();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
